[src/gbp_pkg.sv]
// ----------------------------------------------------------------------------
// gbp_pkg
// Shared types and constants for the gradient background pixel generator.
// ----------------------------------------------------------------------------
package gbp_pkg;

  // fill modes
  localparam logic FILL_SOLID    = 1'b0;
  localparam logic FILL_GRADIENT = 1'b1;

  // gradient directions
  typedef enum logic [1:0] {
    DIR_TOP_BOTTOM = 2'd0,
    DIR_LEFT_RIGHT = 2'd1,
    DIR_TOP_LEFT   = 2'd2,
    DIR_TOP_RIGHT  = 2'd3
  } gbp_dir_t;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_FILL_MODE    = 3'd0,
    REG_DIRECTION    = 3'd1,
    REG_COLOR_ONE    = 3'd2,
    REG_COLOR_TWO    = 3'd3,
    REG_FRAME_WIDTH  = 3'd4,
    REG_FRAME_HEIGHT = 3'd5
  } gbp_reg_t;

  localparam int unsigned CH_W     = 8;   // bits per colour channel
  localparam int unsigned NUM_CH   = 3;   // red, green, blue
  localparam int unsigned DIM_W    = 13;  // frame size register width
  localparam logic [12:0] WIDTH_RST  = 13'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

endpackage

[src/gbp_div_cell.sv]
// ----------------------------------------------------------------------------
// gbp_div_cell
// One restoring division step: settles quotient bit SHIFT for every lane.
// ----------------------------------------------------------------------------
module gbp_div_cell import gbp_pkg::*; #(
  parameter int unsigned LANES = 3,
  parameter int unsigned DW    = 12,
  parameter int unsigned SW    = 1,
  parameter int unsigned SHIFT = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic [DW-1:0]                    divisor,
  input  logic                             v_in,
  input  logic [LANES-1:0][DW+CH_W-1:0]    rem_in,
  input  logic [LANES-1:0][CH_W-1:0]       q_in,
  input  logic [SW-1:0]                    side_in,
  output logic                             v_out_r,
  output logic [LANES-1:0][DW+CH_W-1:0]    rem_out_r,
  output logic [LANES-1:0][CH_W-1:0]       q_out_r,
  output logic [SW-1:0]                    side_out_r
);

  localparam int unsigned RW = DW + CH_W;

  logic [RW-1:0]                 trial;
  logic [LANES-1:0][RW-1:0]      rem_nxt;
  logic [LANES-1:0][CH_W-1:0]    q_nxt;

  // compare and subtract the shifted divisor
  always_comb begin
    trial   = RW'(divisor) << SHIFT;
    rem_nxt = rem_in;
    q_nxt   = q_in;
    for (int l = 0; l < LANES; l++) begin
      if (rem_in[l] >= trial) begin
        rem_nxt[l]      = rem_in[l] - trial;
        q_nxt[l][SHIFT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_out_r <= 1'b0;
    end else if (en) begin
      v_out_r <= v_in;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (en) begin
      rem_out_r  <= rem_nxt;
      q_out_r    <= q_nxt;
      side_out_r <= side_in;
    end
  end

endmodule

[src/gbp_div_chain.sv]
// ----------------------------------------------------------------------------
// gbp_div_chain
// Row of eight division cells giving an 8-bit quotient per lane.
// ----------------------------------------------------------------------------
module gbp_div_chain import gbp_pkg::*; #(
  parameter int unsigned LANES = 3,
  parameter int unsigned DW    = 12,
  parameter int unsigned SW    = 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic [DW-1:0]                    divisor,
  input  logic                             v_in,
  input  logic [LANES-1:0][DW+CH_W-1:0]    num_in,
  input  logic [SW-1:0]                    side_in,
  output logic                             v_out,
  output logic [LANES-1:0][CH_W-1:0]       q_out,
  output logic [SW-1:0]                    side_out
);

  localparam int unsigned RW = DW + CH_W;

  logic [CH_W:0]                           v;
  logic [CH_W:0][LANES-1:0][RW-1:0]        rem;
  logic [CH_W:0][LANES-1:0][CH_W-1:0]      q;
  logic [CH_W:0][SW-1:0]                   side;

  assign v[0]    = v_in;
  assign rem[0]  = num_in;
  assign q[0]    = '0;
  assign side[0] = side_in;

  // most significant quotient bit first
  for (genvar j = 0; j < CH_W; j++) begin : g_cell
    gbp_div_cell #(
      .LANES (LANES),
      .DW    (DW),
      .SW    (SW),
      .SHIFT (CH_W - 1 - j)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .divisor    (divisor),
      .v_in       (v[j]),
      .rem_in     (rem[j]),
      .q_in       (q[j]),
      .side_in    (side[j]),
      .v_out_r    (v[j+1]),
      .rem_out_r  (rem[j+1]),
      .q_out_r    (q[j+1]),
      .side_out_r (side[j+1])
    );
  end

  assign v_out    = v[CH_W];
  assign q_out    = q[CH_W];
  assign side_out = side[CH_W];

endmodule

[src/gradient_background_pixel.sv]
// ----------------------------------------------------------------------------
// gradient_background_pixel
// Background colour per pixel coordinate: solid colour or linear gradient.
// ----------------------------------------------------------------------------
//  channel | ports                         | handshake
//  --------+-------------------------------+------------------------------
//  input   | in_pixel_x, in_pixel_y        | in_valid / in_stall
//  result  | out_pixel_color, out_coord_.. | out_valid / out_stall
//  config  | psel penable pwrite paddr ..  | APB write, pready always high
//
//  One item per clock while in_stall is low. Items pass through a numerator
//  stage, eight division cells for the row blend, a numerator stage and
//  eight division cells for the column blend, then the output register.
//  A two-entry output (register plus skid) lets the pipe run while a result
//  waits; in_stall rises only once the skid entry is occupied.
//  Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module gradient_background_pixel import gbp_pkg::*; #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_pixel_x,
  input  logic [11:0] in_pixel_y,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pixel_color,
  output logic        out_coord_in_range,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned DW = $clog2(MAX_DIM);      // span width
  localparam int unsigned CW = $clog2(MAX_DIM + 1);  // clamped size width
  localparam int unsigned RW = DW + CH_W;            // numerator width

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic             fill_mode_r;
  gbp_dir_t         direction_r;
  logic [31:0]      color_one_r;
  logic [31:0]      color_two_r;
  logic [DIM_W-1:0] frame_width_r;
  logic [DIM_W-1:0] frame_height_r;
  gbp_reg_t         reg_sel;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = gbp_reg_t'(paddr[4:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_mode_r    <= FILL_SOLID;
      direction_r    <= DIR_TOP_BOTTOM;
      color_one_r    <= '0;
      color_two_r    <= '0;
      frame_width_r  <= WIDTH_RST;
      frame_height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_FILL_MODE:    fill_mode_r    <= pwdata[0];
        REG_DIRECTION:    direction_r    <= gbp_dir_t'(pwdata[1:0]);
        REG_COLOR_ONE:    color_one_r    <= pwdata;
        REG_COLOR_TWO:    color_two_r    <= pwdata;
        REG_FRAME_WIDTH:  frame_width_r  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_sel)
      REG_FILL_MODE:    prdata = {31'd0, fill_mode_r};
      REG_DIRECTION:    prdata = {30'd0, direction_r};
      REG_COLOR_ONE:    prdata = color_one_r;
      REG_COLOR_TWO:    prdata = color_two_r;
      REG_FRAME_WIDTH:  prdata = {19'd0, frame_width_r};
      REG_FRAME_HEIGHT: prdata = {19'd0, frame_height_r};
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // frame size: clamp, then spans with a zero span read as one
  // --------------------------------------------------------------------------
  logic [CW-1:0] wd_c, ht_c;
  logic [DW-1:0] w_span, h_span;

  always_comb begin
    wd_c   = (32'(frame_width_r) > 32'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(frame_width_r);
    ht_c   = (32'(frame_height_r) > 32'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(frame_height_r);
    w_span = (wd_c <= CW'(1)) ? DW'(1) : DW'(wd_c - CW'(1));
    h_span = (ht_c <= CW'(1)) ? DW'(1) : DW'(ht_c - CW'(1));
  end

  // --------------------------------------------------------------------------
  // pipe advance and skid
  // --------------------------------------------------------------------------
  logic skid_v_r;
  logic adv;

  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;

  // --------------------------------------------------------------------------
  // stage 0: row blend numerators, two per channel
  // --------------------------------------------------------------------------
  logic                              in_frame;
  logic [DW-1:0]                     row_i;
  logic [2*NUM_CH-1:0][CH_W-1:0]     ep_a, ep_b;
  logic [2*NUM_CH-1:0][RW-1:0]       num1;
  logic                              s0_v_r;
  logic [2*NUM_CH-1:0][RW-1:0]       s0_num_r;
  logic [12:0]                       s0_side_r;

  always_comb begin
    logic [CH_W-1:0] c1, c2, mid;
    in_frame = (32'(in_pixel_x) < 32'(wd_c)) && (32'(in_pixel_y) < 32'(ht_c));
    row_i    = DW'(in_pixel_y);
    for (int k = 0; k < NUM_CH; k++) begin
      c1  = color_one_r[CH_W*(NUM_CH-1-k) +: CH_W];
      c2  = color_two_r[CH_W*(NUM_CH-1-k) +: CH_W];
      mid = CH_W'(({1'b0, c1} + {1'b0, c2}) >> 1);
      case (direction_r)
        DIR_TOP_BOTTOM: begin
          ep_a[2*k] = c1;  ep_b[2*k] = c2;
          ep_a[2*k+1] = c1;  ep_b[2*k+1] = c2;
        end
        DIR_LEFT_RIGHT: begin
          ep_a[2*k] = c1;  ep_b[2*k] = c1;
          ep_a[2*k+1] = c2;  ep_b[2*k+1] = c2;
        end
        DIR_TOP_LEFT: begin
          ep_a[2*k] = c1;  ep_b[2*k] = mid;
          ep_a[2*k+1] = mid; ep_b[2*k+1] = c2;
        end
        default: begin
          ep_a[2*k] = mid; ep_b[2*k] = c1;
          ep_a[2*k+1] = c2;  ep_b[2*k+1] = mid;
        end
      endcase
    end
    // a*(n-i) + b*i, i <= n whenever the pixel is inside
    for (int l = 0; l < 2*NUM_CH; l++) begin
      num1[l] = RW'(RW'(ep_a[l]) * RW'(h_span - row_i)) + RW'(RW'(ep_b[l]) * RW'(row_i));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_num_r  <= num1;
      s0_side_r <= {in_frame, in_pixel_x};
    end
  end

  // --------------------------------------------------------------------------
  // row blend division
  // --------------------------------------------------------------------------
  logic                            d1_v;
  logic [2*NUM_CH-1:0][CH_W-1:0]   d1_q;
  logic [12:0]                     d1_side;

  gbp_div_chain #(.LANES(2*NUM_CH), .DW(DW), .SW(13)) u_row_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .divisor  (h_span),
    .v_in     (s0_v_r),
    .num_in   (s0_num_r),
    .side_in  (s0_side_r),
    .v_out    (d1_v),
    .q_out    (d1_q),
    .side_out (d1_side)
  );

  // --------------------------------------------------------------------------
  // stage 1: column blend numerators between the two row edges
  // --------------------------------------------------------------------------
  logic [DW-1:0]               col_i;
  logic [NUM_CH-1:0][RW-1:0]   num2;
  logic                        s1_v_r;
  logic [NUM_CH-1:0][RW-1:0]   s1_num_r;
  logic                        s1_inside_r;

  always_comb begin
    col_i = DW'(d1_side[11:0]);
    for (int k = 0; k < NUM_CH; k++) begin
      num2[k] = RW'(RW'(d1_q[2*k]) * RW'(w_span - col_i)) + RW'(RW'(d1_q[2*k+1]) * RW'(col_i));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_num_r    <= num2;
      s1_inside_r <= d1_side[12];
    end
  end

  // --------------------------------------------------------------------------
  // column blend division
  // --------------------------------------------------------------------------
  logic                        d2_v;
  logic [NUM_CH-1:0][CH_W-1:0] d2_q;
  logic                        d2_inside;

  gbp_div_chain #(.LANES(NUM_CH), .DW(DW), .SW(1)) u_col_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .divisor  (w_span),
    .v_in     (s1_v_r),
    .num_in   (s1_num_r),
    .side_in  (s1_inside_r),
    .v_out    (d2_v),
    .q_out    (d2_q),
    .side_out (d2_inside)
  );

  // --------------------------------------------------------------------------
  // result assembly
  // --------------------------------------------------------------------------
  logic [31:0] pipe_color;

  always_comb begin
    if (!d2_inside) begin
      pipe_color = '0;
    end else if (fill_mode_r == FILL_GRADIENT) begin
      pipe_color = {ALPHA_OPAQUE, d2_q[0], d2_q[1], d2_q[2]};
    end else begin
      pipe_color = color_one_r;
    end
  end

  // --------------------------------------------------------------------------
  // output register and skid entry
  // --------------------------------------------------------------------------
  logic        out_v_r;
  logic [31:0] out_color_r, skid_color_r;
  logic        out_inside_r, skid_inside_r;
  logic        out_free;

  assign out_free = !out_v_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (adv && d2_v) begin
      if (out_free) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (skid_v_r && out_free) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && d2_v) begin
      if (out_free) begin
        out_color_r  <= pipe_color;
        out_inside_r <= d2_inside;
      end else begin
        skid_color_r  <= pipe_color;
        skid_inside_r <= d2_inside;
      end
    end else if (skid_v_r && out_free) begin
      out_color_r  <= skid_color_r;
      out_inside_r <= skid_inside_r;
    end
  end

  assign out_valid          = out_v_r;
  assign out_pixel_color    = out_color_r;
  assign out_coord_in_range = out_inside_r;

endmodule

[src/gbp_checker.sv]
// ----------------------------------------------------------------------------
// gbp_checker
// Port-level checks for the gradient background pixel generator.
// ----------------------------------------------------------------------------
module gbp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_pixel_color,
  input logic        out_coord_in_range,
  input logic        pready
);

  // a stalled item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  // a stalled item keeps its colour
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_pixel_color))
    else $error("result colour changed while stalled");

  // a pixel outside the frame is black and transparent
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_coord_in_range |-> out_pixel_color == 32'd0)
    else $error("outside pixel with non-zero colour");

  // input is held back only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled with no stalled result");

  // configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind gradient_background_pixel gbp_checker u_gbp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_pixel_color    (out_pixel_color),
  .out_coord_in_range (out_coord_in_range),
  .pready             (pready)
);

[verif/tb_gradient_background_pixel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gradient_background_pixel
// Self-checking bench for the gradient background pixel generator.
// ----------------------------------------------------------------------------
// Pixel coordinates are queued by a stimulus process and sent by a clocked
// driver with random gaps. A clocked monitor stalls the result side at random
// and checks every result against a colour predictor kept in the bench. The
// run steps through solid and gradient fills, all four directions, extreme
// colours and frame sizes from zero up past the largest supported dimension.
// ----------------------------------------------------------------------------
module tb_gradient_background_pixel import gbp_pkg::*;;

  localparam int unsigned CLK_HALF   = 6;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_CYC  = 25;
  localparam int unsigned N_PHASES   = 16;
  localparam int unsigned PER_PHASE  = 90;
  localparam int unsigned MAX_DIM    = 4096;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
  } pix_req_t;

  typedef struct packed {
    logic [31:0] color;
    logic        in_range;
  } pix_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [11:0] in_pixel_x;
  logic [11:0] in_pixel_y;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_pixel_color;
  logic        out_coord_in_range;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // bench copy of the register file
  logic        m_fill;
  gbp_dir_t    m_dir;
  logic [31:0] m_c1;
  logic [31:0] m_c2;
  logic [12:0] m_width;
  logic [12:0] m_frame_h;

  pix_req_t    pending_q[$];
  pix_res_t    colour_q[$];
  int unsigned n_fail    = 0;
  int unsigned n_sent    = 0;
  int unsigned n_checked = 0;
  int unsigned idle_cnt  = 0;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          burst;

  gradient_background_pixel u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pixel_x         (in_pixel_x),
    .in_pixel_y         (in_pixel_y),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pixel_color    (out_pixel_color),
    .out_coord_in_range (out_coord_in_range),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // clock
  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // truncating linear blend, first endpoint on a zero span
  function automatic int unsigned blend(int unsigned a, int unsigned b,
                                        int unsigned i, int unsigned n);
    if (n == 0) return a;
    return (a * (n - i) + b * i) / n;
  endfunction

  // expected colour for one coordinate under the current registers
  function automatic pix_res_t background_colour(pix_req_t req);
    pix_res_t    r;
    int unsigned wd, ht, c1, c2, mid, lft, rgt, ch;
    wd = (m_width > MAX_DIM) ? MAX_DIM : m_width;
    ht = (m_frame_h > MAX_DIM) ? MAX_DIM : m_frame_h;
    r.in_range = (req.x < wd) && (req.y < ht);
    r.color = '0;
    if (r.in_range) begin
      if (m_fill == FILL_SOLID) begin
        r.color = m_c1;
      end else begin
        r.color[31:24] = ALPHA_OPAQUE;
        for (int k = 0; k < NUM_CH; k++) begin
          c1  = (m_c1 >> (16 - 8 * k)) & 8'hFF;
          c2  = (m_c2 >> (16 - 8 * k)) & 8'hFF;
          mid = (c1 + c2) / 2;
          case (m_dir)
            DIR_TOP_BOTTOM: ch = blend(c1, c2, req.y, ht - 1);
            DIR_LEFT_RIGHT: ch = blend(c1, c2, req.x, wd - 1);
            DIR_TOP_LEFT: begin
              lft = blend(c1, mid, req.y, ht - 1);
              rgt = blend(mid, c2, req.y, ht - 1);
              ch  = blend(lft, rgt, req.x, wd - 1);
            end
            default: begin
              lft = blend(mid, c1, req.y, ht - 1);
              rgt = blend(c2, mid, req.y, ht - 1);
              ch  = blend(lft, rgt, req.x, wd - 1);
            end
          endcase
          r.color[16 - 8 * k +: 8] = ch[7:0];
        end
      end
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_checked);
    n_fail++;
  endtask

  // driver: send queued coordinates, random gap per item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_pixel_x <= '0;
      in_pixel_y <= '0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        colour_q.push_back(background_colour(pix_req_t'{x: in_pixel_x, y: in_pixel_y}));
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_q.size() != 0) begin
          pix_req_t req;
          req = pending_q.pop_front();
          in_pixel_x <= req.x;
          in_pixel_y <= req.y;
          in_valid   <= 1'b1;
          gap_left   <= burst ? 0 : $urandom_range(0, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result, random stall per item
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (colour_q.size() == 0) begin
          report("unexpected item", out_pixel_color, '0);
        end else begin
          pix_res_t want;
          want = colour_q.pop_front();
          if (out_pixel_color !== want.color)
            report("pixel_color", out_pixel_color, want.color);
          if (out_coord_in_range !== want.in_range)
            report("coord_in_range", 32'(out_coord_in_range), 32'(want.in_range));
        end
        n_checked++;
        stall_left = burst ? 0 : $urandom_range(0, 9);
      end
      if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left = stall_left - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cnt <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cnt);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // register write: setup cycle then access cycle
  task automatic reg_write(gbp_reg_t idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FILL_MODE:    m_fill    = val[0];
      REG_DIRECTION:    m_dir     = gbp_dir_t'(val[1:0]);
      REG_COLOR_ONE:    m_c1      = val;
      REG_COLOR_TWO:    m_c2      = val;
      REG_FRAME_WIDTH:  m_width   = val[12:0];
      REG_FRAME_HEIGHT: m_frame_h = val[12:0];
      default: ;
    endcase
  endtask

  // sampled between edges so the driver and monitor updates have settled
  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || colour_q.size() != 0) @(negedge clk);
  endtask

  // frame dimension picks, covering zero, one, the maximum and oversize
  function automatic logic [12:0] pick_dim(int unsigned sel);
    case (sel % 8)
      0: return 13'd1;
      1: return 13'd2;
      2: return 13'd4096;
      3: return 13'd8191;
      4: return 13'd0;
      5: return 13'($urandom_range(3, 64));
      6: return 13'($urandom_range(3, 4096));
      default: return 13'd4097;
    endcase
  endfunction

  // coordinate mostly inside the frame, sometimes anywhere
  function automatic pix_req_t pick_pixel();
    pix_req_t    req;
    int unsigned wd, ht;
    wd = (m_width > MAX_DIM) ? MAX_DIM : m_width;
    ht = (m_frame_h > MAX_DIM) ? MAX_DIM : m_frame_h;
    req.x = 12'($urandom);
    req.y = 12'($urandom);
    if (wd != 0 && $urandom_range(0, 4) != 0) req.x = 12'($urandom_range(0, wd - 1));
    if (ht != 0 && $urandom_range(0, 4) != 0) req.y = 12'($urandom_range(0, ht - 1));
    return req;
  endfunction

  task automatic push_edges();
    int unsigned wd, ht;
    wd = (m_width > MAX_DIM) ? MAX_DIM : m_width;
    ht = (m_frame_h > MAX_DIM) ? MAX_DIM : m_frame_h;
    pending_q.push_back('{x: 12'd0, y: 12'd0});
    pending_q.push_back('{x: 12'hFFF, y: 12'hFFF});
    pending_q.push_back('{x: 12'(wd - 1), y: 12'(ht - 1)});
    pending_q.push_back('{x: 12'(wd - 1), y: 12'd0});
    pending_q.push_back('{x: 12'd0, y: 12'(ht - 1)});
    pending_q.push_back('{x: 12'(wd), y: 12'd0});
    pending_q.push_back('{x: 12'd0, y: 12'(ht)});
  endtask

  // stimulus
  initial begin
    rst_n     = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    burst     = 1'b0;
    m_fill    = FILL_SOLID;
    m_dir     = DIR_TOP_BOTTOM;
    m_c1      = '0;
    m_c2      = '0;
    m_width   = WIDTH_RST;
    m_frame_h = HEIGHT_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset registers, frame corners and just outside
    push_edges();
    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);

    for (int p = 0; p < N_PHASES; p++) begin
      logic [31:0] c1, c2;
      c1 = $urandom;
      c2 = $urandom;
      if (p == 1) begin c1 = 32'h0; c2 = 32'hFFFF_FFFF; end
      if (p == 2) begin c1 = 32'hFFFF_FFFF; c2 = 32'h0; end
      reg_write(REG_FILL_MODE, 32'((p % 5 == 0) ? FILL_SOLID : FILL_GRADIENT));
      reg_write(REG_DIRECTION, 32'(p % 4));
      reg_write(REG_COLOR_ONE, c1);
      reg_write(REG_COLOR_TWO, c2);
      reg_write(REG_FRAME_WIDTH, 32'(pick_dim(p)));
      reg_write(REG_FRAME_HEIGHT, 32'(pick_dim(p + 3)));
      burst = (p % 3 == 0);
      if (p < 4) push_edges();
      for (int i = 0; i < PER_PHASE / 2; i++) pending_q.push_back(pick_pixel());
      // hold off until the pipe has emptied
      wait_drained();
      for (int i = 0; i < PER_PHASE / 2; i++) pending_q.push_back(pick_pixel());
      wait_drained();
      repeat (DRAIN_CYC) @(posedge clk);
    end

    burst = 1'b0;
    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);
    if (colour_q.size() != 0) report("items left over", 32'(colour_q.size()), '0);

    $display("%0d coordinates sent, %0d results checked over %0d register settings",
             n_sent, n_checked, N_PHASES + 1);
    $display("solid and gradient fills, all directions, frames from 0 to beyond 4096");
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
